// ----- rtl/bbc_pkg.sv -----
// Package for the bracket balance checker: item types, result kinds, bracket codes,
// controller state and the command/status structs between controller and datapath.
// No dependencies.
package bbc_pkg;

  // Sizes
  localparam int unsigned STACK_DEPTH   = 32;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned PTR_W         = $clog2(STACK_DEPTH);
  localparam int unsigned LEVEL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OUT_POS_W     = 16;
  localparam int unsigned ERR_W         = 16;

  // Bracket bytes
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]

  typedef enum logic [2:0] {
    KIND_UNMATCHED_CLOSE = 3'd0,
    KIND_MISMATCH        = 3'd1,
    KIND_UNMATCHED_OPEN  = 3'd2,
    KIND_OVERFLOW        = 3'd3,
    KIND_SUMMARY         = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BR_ROUND  = 2'd0,
    BR_CURLY  = 2'd1,
    BR_SQUARE = 2'd2
  } bracket_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_DRAIN   = 2'd1,
    ST_SUMMARY = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       has_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [OUT_POS_W-1:0]   position;
    logic [7:0]             open_bracket;
    logic [7:0]             close_bracket;
    logic [ERR_W-1:0]       error_count;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    bracket_e             code;
    logic [OUT_POS_W-1:0] pos;
  } stack_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic pop_drain;
    logic emit_summary;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic level_zero;
  } stat_t;

  function automatic logic is_open_char(logic [7:0] c);
    return (c == CH_OPEN_ROUND) || (c == CH_OPEN_CURLY) || (c == CH_OPEN_SQUARE);
  endfunction

  function automatic logic is_close_char(logic [7:0] c);
    return (c == CH_CLOSE_ROUND) || (c == CH_CLOSE_CURLY) || (c == CH_CLOSE_SQUARE);
  endfunction

  // Bracket kind of an opening or closing byte
  function automatic bracket_e code_of(logic [7:0] c);
    bracket_e r;
    r = BR_ROUND;
    if ((c == CH_OPEN_CURLY) || (c == CH_CLOSE_CURLY)) begin
      r = BR_CURLY;
    end else if ((c == CH_OPEN_SQUARE) || (c == CH_CLOSE_SQUARE)) begin
      r = BR_SQUARE;
    end
    return r;
  endfunction

  function automatic logic [7:0] open_char_of(bracket_e code);
    logic [7:0] r;
    unique case (code)
      BR_ROUND:  r = CH_OPEN_ROUND;
      BR_CURLY:  r = CH_OPEN_CURLY;
      BR_SQUARE: r = CH_OPEN_SQUARE;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bbc_ctrl.sv -----
// Controller of the bracket balance checker: takes items, sequences the
// end-of-text drain and the summary. Depends on bbc_pkg.
module bbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          end_of_text_i,
  output logic          in_ready_o,
  input  bbc_pkg::stat_t stat_i,
  output bbc_pkg::cmd_t  cmd_o
);

  bbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbc_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.slot_free && end_of_text_i) begin
          state_d = bbc_pkg::ST_DRAIN;
        end
      end
      bbc_pkg::ST_DRAIN: begin
        if (stat_i.level_zero) begin
          state_d = bbc_pkg::ST_SUMMARY;
        end
      end
      bbc_pkg::ST_SUMMARY: begin
        if (stat_i.slot_free) begin
          state_d = bbc_pkg::ST_IDLE;
        end
      end
      default: state_d = bbc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    unique case (state_q)
      bbc_pkg::ST_IDLE: begin
        in_ready_o      = stat_i.slot_free;
        cmd_o.load_item = in_valid_i && stat_i.slot_free;
      end
      bbc_pkg::ST_DRAIN: begin
        cmd_o.pop_drain = !stat_i.level_zero && stat_i.slot_free;
      end
      bbc_pkg::ST_SUMMARY: begin
        cmd_o.emit_summary = stat_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/bbc_dpath.sv -----
// Datapath of the bracket balance checker: bracket stack, position and error
// counters, result register. Driven by bbc_ctrl commands. Depends on bbc_pkg.
module bbc_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbc_pkg::in_item_t  in_item_i,
  input  bbc_pkg::cmd_t      cmd_i,
  output bbc_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbc_pkg::out_item_t out_item_o
);

  localparam int unsigned LW = bbc_pkg::LEVEL_W;
  localparam int unsigned PW = bbc_pkg::PTR_W;
  localparam int unsigned QW = bbc_pkg::POSITION_BITS;
  localparam int unsigned EW = bbc_pkg::ERR_W;
  localparam int unsigned OW = bbc_pkg::OUT_POS_W;

  bbc_pkg::stack_entry_t stack_q [bbc_pkg::STACK_DEPTH];

  logic [LW-1:0] level_q, level_d;
  logic [QW-1:0] pos_q, pos_d;
  logic [EW-1:0] errs_q, errs_d;
  logic          out_valid_q, out_valid_d;
  bbc_pkg::out_item_t out_q;

  logic [LW-1:0]         level_m1;
  bbc_pkg::stack_entry_t top;
  bbc_pkg::stack_entry_t push_entry;
  logic                  push;
  logic                  err_inc;
  logic                  clear;
  logic                  res_valid;
  bbc_pkg::out_item_t    res;
  logic                  full;

  assign level_m1 = level_q - LW'(1);
  assign top      = stack_q[level_m1[PW-1:0]];
  assign full     = (level_q == LW'(bbc_pkg::STACK_DEPTH));

  assign push_entry.code = bbc_pkg::code_of(in_item_i.char_in);
  assign push_entry.pos  = OW'(pos_q);

  always_comb begin
    level_d   = level_q;
    pos_d     = pos_q;
    push      = 1'b0;
    err_inc   = 1'b0;
    clear     = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (cmd_i.load_item && in_item_i.has_char) begin
      if (pos_q != '1) begin
        pos_d = pos_q + QW'(1);
      end
      if (bbc_pkg::is_open_char(in_item_i.char_in)) begin
        if (!full) begin
          push    = 1'b1;
          level_d = level_q + LW'(1);
        end else begin
          err_inc          = 1'b1;
          res_valid        = 1'b1;
          res.kind         = bbc_pkg::KIND_OVERFLOW;
          res.position     = OW'(pos_q);
          res.open_bracket = in_item_i.char_in;
        end
      end else if (bbc_pkg::is_close_char(in_item_i.char_in)) begin
        if (level_q == '0) begin
          err_inc           = 1'b1;
          res_valid         = 1'b1;
          res.kind          = bbc_pkg::KIND_UNMATCHED_CLOSE;
          res.position      = OW'(pos_q);
          res.close_bracket = in_item_i.char_in;
        end else begin
          level_d = level_m1;
          if (top.code != bbc_pkg::code_of(in_item_i.char_in)) begin
            err_inc           = 1'b1;
            res_valid         = 1'b1;
            res.kind          = bbc_pkg::KIND_MISMATCH;
            res.position      = OW'(pos_q);
            res.open_bracket  = bbc_pkg::open_char_of(top.code);
            res.close_bracket = in_item_i.char_in;
          end
        end
      end
    end

    if (cmd_i.pop_drain) begin
      level_d          = level_m1;
      err_inc          = 1'b1;
      res_valid        = 1'b1;
      res.kind         = bbc_pkg::KIND_UNMATCHED_OPEN;
      res.position     = top.pos;
      res.open_bracket = bbc_pkg::open_char_of(top.code);
    end

    if (cmd_i.emit_summary) begin
      level_d         = '0;
      pos_d           = '0;
      clear           = 1'b1;
      res_valid       = 1'b1;
      res.kind        = bbc_pkg::KIND_SUMMARY;
      res.error_count = errs_q;
      res.last        = 1'b1;
    end
  end

  always_comb begin
    errs_d = errs_q;
    if (clear) begin
      errs_d = '0;
    end else if (err_inc && (errs_q != '1)) begin
      errs_d = errs_q + EW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      pos_q       <= '0;
      errs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      pos_q       <= pos_d;
      errs_q      <= errs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stack and result payload: no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[level_q[PW-1:0]] <= push_entry;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign stat_o.slot_free  = !out_valid_q || out_ready_i;
  assign stat_o.level_zero = (level_q == '0);
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ----- rtl/bracket_balance_checker_core.sv -----
// A result caused by a byte is shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the result register is free or being taken.
// After an end-of-text item no item is taken until the stack entries left have been
// drained, one result each, and the summary sent; each waits for a free result register.
// Reset (rst_ni, asynchronous, active low) empties the stack and clears the position
// and error counters and the result register's valid flag.
module bracket_balance_checker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Text items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbc_pkg::in_item_t  in_item_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbc_pkg::out_item_t out_item_o
);

  // Command and status between the two halves
  bbc_pkg::cmd_t  cmd;
  bbc_pkg::stat_t stat;

  // Controller: accept items, walk the stack down at end of text, then send
  // the summary. An item is taken only while the result register is free or
  // is being emptied in the same cycle, so a result is never overwritten.
  bbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_text_i (in_item_i.end_of_text),
    .in_ready_o    (in_ready_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Datapath: hold the bracket stack (kind code and position per entry),
  // advance the saturating position counter on every valid byte, count errors
  // with saturation and drop them after the summary, and hold the result.
  bbc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/bbc_checker.sv -----
// Port-level checks for bracket_balance_checker_core, attached by bind.
// Depends on bbc_pkg.
module bbc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bbc_pkg::out_item_t out_item_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // Take no item while a result waits
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while result stalled");

  // Summary and only summary carries last
  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.kind == bbc_pkg::KIND_SUMMARY) == out_item_o.last))
    else $error("last flag does not match summary kind");

  // Error count only in the summary
  a_count_only_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.error_count == '0)
    else $error("error count outside summary");

  // Summary carries no position or brackets
  a_summary_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |->
      out_item_o.position == '0 && out_item_o.open_bracket == '0 &&
      out_item_o.close_bracket == '0)
    else $error("summary carries bracket fields");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
